/* design/rmed_pkg.sv */
// Shared constants and types for the running median block.
package rmed_pkg;

    localparam int CAPACITY   = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GROUP      = 32;
    localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                valid;
        logic                big;
    } cell_link_t;

    typedef struct packed {
        logic [IDX_W-1:0] lo_idx;
        logic [IDX_W-1:0] hi_idx;
    } mid_sel_t;

endpackage

/* design/rmed_cell.sv */
// One sorted cell: holds a value, shifts right on insertion, flags the middle entries.
module rmed_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rmed_pkg::IDX_W-1:0]   cell_idx,
    input  logic                         shift_en,
    input  logic [rmed_pkg::SAMPLE_W-1:0] sample,
    input  rmed_pkg::cell_link_t         left,
    output rmed_pkg::cell_link_t         right,
    input  rmed_pkg::mid_sel_t           sel,
    output logic [rmed_pkg::SAMPLE_W-1:0] lo_lane,
    output logic [rmed_pkg::SAMPLE_W-1:0] hi_lane
);
    import rmed_pkg::*;

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic                valid_reg;
    logic                valid_next;
    logic                big;

    assign big = !valid_reg || ($signed(value_reg) > $signed(sample));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (shift_en)
        begin
            valid_next = valid_reg | left.valid;
            if (left.big)
                value_next = left.value;
            else if (big)
                value_next = sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign right.value = value_reg;
    assign right.valid = valid_reg;
    assign right.big   = big;

    assign lo_lane = (cell_idx == sel.lo_idx) ? value_reg : '0;
    assign hi_lane = (cell_idx == sel.hi_idx) ? value_reg : '0;

endmodule

/* design/rmed_reduce.sv */
// Two-level OR tree, group level registered, that gathers the one flagged lane of the cell row.
module rmed_reduce (
    input  logic                          clk,
    input  logic                          load,
    input  logic [rmed_pkg::SAMPLE_W-1:0] lane [rmed_pkg::CAPACITY],
    output logic [rmed_pkg::SAMPLE_W-1:0] total
);
    import rmed_pkg::*;

    logic [SAMPLE_W-1:0] group_reg  [NUM_GROUPS];
    logic [SAMPLE_W-1:0] group_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CAPACITY)
                    group_next[g] = group_next[g] | lane[g * GROUP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                group_reg[g] <= group_next[g];
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
            total = total | group_reg[g];
    end

endmodule

/* design/running_median.sv */
// Top level of the running median: cell row, middle-entry gather and result register.
// The result passes through the GATHER state (group gather), then the REDUCE state (final sum).
// A new sample is taken only in IDLE, not during gather or sum; a result left untaken stalls the
// sum, and with it the next transfer, until the result register frees.
// The cell row inserts a sample in order at the edge of its transfer, unless the row is full.
// Reset clears the held count, the cell valid flags and the result register; no clearing pass.
module running_median (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [rmed_pkg::SAMPLE_W-1:0] sample_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [rmed_pkg::MEDIAN_W-1:0] median_doubled,
    output logic [rmed_pkg::CNT_W-1:0]      held_count,
    output logic                            overflow
);
    import rmed_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        GATHER,
        REDUCE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [MEDIAN_W-1:0]  median_reg;
    logic [MEDIAN_W-1:0]  median_next;
    logic [CNT_W-1:0]     held_reg;
    logic [CNT_W-1:0]     held_next;
    logic                 ovf_out_reg;
    logic                 ovf_out_next;

    logic                 in_xfer;
    logic                 full;
    logic                 shift_en;
    logic [IDX_W-1:0]     half;
    mid_sel_t             sel;
    cell_link_t           link [CAPACITY+1];
    logic [SAMPLE_W-1:0]  lo_lane [CAPACITY];
    logic [SAMPLE_W-1:0]  hi_lane [CAPACITY];
    logic [SAMPLE_W-1:0]  lo_total;
    logic [SAMPLE_W-1:0]  hi_total;

    assign in_ready = (state_reg == IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign shift_en = in_xfer && !full;

    assign half       = IDX_W'(count_reg >> 1);
    assign sel.hi_idx = half;
    assign sel.lo_idx = count_reg[0] ? half : half - IDX_W'(1);

    assign link[0].value = '0;
    assign link[0].valid = 1'b1;
    assign link[0].big   = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        rmed_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .shift_en (shift_en),
            .sample   (sample_value),
            .left     (link[i]),
            .right    (link[i+1]),
            .sel      (sel),
            .lo_lane  (lo_lane[i]),
            .hi_lane  (hi_lane[i])
        );
    end

    rmed_reduce u_reduce_lo (
        .clk   (clk),
        .load  (state_reg == GATHER),
        .lane  (lo_lane),
        .total (lo_total)
    );

    rmed_reduce u_reduce_hi (
        .clk   (clk),
        .load  (state_reg == GATHER),
        .lane  (hi_lane),
        .total (hi_total)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        held_next      = held_reg;
        ovf_out_next   = ovf_out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (in_xfer)
                begin
                    ovf_next   = full;
                    state_next = GATHER;
                    if (!full)
                        count_next = count_reg + CNT_W'(1);
                end
            end
            GATHER:
            begin
                state_next = REDUCE;
            end
            REDUCE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    median_next    = {lo_total[SAMPLE_W-1], lo_total}
                                   + {hi_total[SAMPLE_W-1], hi_total};
                    held_next      = count_reg;
                    ovf_out_next   = ovf_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            held_reg      <= '0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            median_reg    <= median_next;
            held_reg      <= held_next;
            ovf_out_reg   <= ovf_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = $signed(median_reg);
    assign held_count     = held_reg;
    assign overflow       = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_out_reg) |-> (held_reg == CNT_W'(CAPACITY)))
        else $error("overflow reported below capacity");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (held_reg != '0))
        else $error("result given for an empty set");

    a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("held count failed to advance on insertion");

endmodule
